FILE: src/rhist_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rhist_pkg
// Shared constants and types for the row histogram block.
// ============================================================================
package rhist_pkg;

    // Default sizes of the bin store.
    localparam int NUM_BINS_DEF    = 101;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field layout of the request stream.
    localparam int SAMPLE_W  = 19;
    localparam int FRAC_BITS = 16;
    localparam int SEL_W     = 7;
    localparam int SCALE_W   = 7;
    localparam logic [SCALE_W-1:0] SCALE = 7'd100;

    // Request kinds carried on tuser.
    typedef enum logic
    {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

endpackage

FILE: src/rhist_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rhist_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module rhist_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 101
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/rhist_addr.sv
`timescale 1ns / 1ps
// ============================================================================
// rhist_addr
// Maps a request to its bin address: the scaled, clamped sample for an add,
// or the selected bin for a read.
// ============================================================================
module rhist_addr
    import rhist_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  cmd_t                        cmd,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic [SEL_W-1:0]            bin_select,
    output logic [$clog2(NUM_BINS)-1:0] addr,
    output logic                        in_range
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int PROD_W = SAMPLE_W - 1 + SCALE_W;
    localparam int IDX_W  = PROD_W - FRAC_BITS;

    logic [SAMPLE_W-2:0] magnitude;
    logic [PROD_W-1:0]   product;
    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   add_addr;

    // The sample is known non-negative when used, so the sign bit drops out.
    assign magnitude = sample[SAMPLE_W-2:0];
    assign product   = PROD_W'(magnitude) * PROD_W'(SCALE);
    assign idx       = product[PROD_W-1:FRAC_BITS];

    always_comb
    begin
        if (sample[SAMPLE_W-1])
        begin
            add_addr = '0;
        end
        else if (32'(idx) > NUM_BINS - 1)
        begin
            add_addr = ADDR_W'(NUM_BINS - 1);
        end
        else
        begin
            add_addr = ADDR_W'(idx);
        end
    end

    always_comb
    begin
        case (cmd)
            CMD_ADD:
            begin
                addr     = add_addr;
                in_range = 1'b1;
            end
            CMD_READ:
            begin
                addr     = ADDR_W'(bin_select);
                in_range = (32'(bin_select) < NUM_BINS);
            end
            default:
            begin
                addr     = add_addr;
                in_range = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/row_histogram_101_bins.sv
`timescale 1ns / 1ps
// Results: a read request accepted into the stage has its count registered
// out of the bin RAM, then in the output register that drives m_axis; add
// requests produce no result.
// Throughput: one request per cycle, set by the single read-modify-write
// pass through the bin RAM; a read stalls only while the output is full.
// Reset: after rst_n is released the bins are cleared by a pass over all
// NUM_BINS entries, one entry per cycle, during which no request is accepted.
// ============================================================================
// row_histogram_101_bins
// Row histogram of fixed-point similarity scores into NUM_BINS bins.
// ============================================================================
module row_histogram_101_bins
    import rhist_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields, lowest bit up: sample (19, signed), bin_select (7), zero pad.
    input  logic [31:0] s_axis_tdata,
    // tuser fields: command (1), 0 = add sample, 1 = read and clear a bin.
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields, lowest bit up: count (COUNT_WIDTH), bin_number (7), zero pad.
    output logic [((COUNT_WIDTH + SEL_W + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int OUT_W  = ((COUNT_WIDTH + SEL_W + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - COUNT_WIDTH - SEL_W;

    // Request fields as unpacked from the slave side.
    cmd_t                       in_cmd;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [SEL_W-1:0]           in_sel;
    logic [ADDR_W-1:0]          in_addr;
    logic                       in_range;
    logic                       accept;

    // The clear pass walks the whole store once after reset.
    logic              clear_busy_reg, clear_busy_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // Stage holding the request whose RAM read is in flight.
    logic              s1_valid_reg, s1_valid_next;
    cmd_t              s1_cmd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_range_reg;
    logic [SEL_W-1:0]  s1_sel_reg;
    logic              s1_done;

    // Last value written into the RAM, used to bypass a read that was
    // issued in the same cycle as a write to the same bin.
    logic                   fwd_valid_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] old_count;
    logic [COUNT_WIDTH-1:0] new_count;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    // Output register.
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic [SEL_W-1:0]       out_bin_reg;
    logic                   out_free;

    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign in_sel    = s_axis_tdata[SAMPLE_W + SEL_W - 1:SAMPLE_W];

    rhist_addr #(
        .NUM_BINS (NUM_BINS)
    ) u_addr (
        .cmd        (in_cmd),
        .sample     (in_sample),
        .bin_select (in_sel),
        .addr       (in_addr),
        .in_range   (in_range)
    );

    // A read request can only leave the stage when the output register is
    // free or being drained in this cycle; adds always leave at once.
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s1_done  = s1_valid_reg && ((s1_cmd_reg == CMD_ADD) || out_free);

    assign s_axis_tready = !clear_busy_reg && (!s1_valid_reg || s1_done);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Bypass the RAM when the bin was written at the edge that launched the read.
    assign old_count = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                         : ram_rdata;

    always_comb
    begin
        case (s1_cmd_reg)
            CMD_ADD:
            begin
                // Saturating increment.
                new_count = (&old_count) ? old_count : old_count + 1'b1;
            end
            CMD_READ:
            begin
                new_count = '0;
            end
            default:
            begin
                new_count = old_count;
            end
        endcase
    end

    // The clear pass owns the write port until it finishes; no request is
    // in flight while it runs.
    always_comb
    begin
        if (clear_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_done && s1_range_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = new_count;
        end
    end

    rhist_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            if (32'(clear_addr_reg) == NUM_BINS - 1)
            begin
                clear_busy_next = 1'b0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= s1_valid_next;
            if (ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_done && (s1_cmd_reg == CMD_READ))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_addr_reg  <= in_addr;
            s1_range_reg <= in_range;
            s1_sel_reg   <= in_sel;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_done && (s1_cmd_reg == CMD_READ))
        begin
            // A bin that does not exist reads as zero.
            out_count_reg <= s1_range_reg ? old_count : '0;
            out_bin_reg   <= s1_sel_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_bin_reg, out_count_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The clear pass and an in-flight request never share the write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !s1_valid_reg && !s_axis_tready)
    else $error("request in flight during the clear pass");

    // A request held by a full output stays in the stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_done |=> s1_valid_reg && $stable(s1_addr_reg))
    else $error("stalled request lost");

    // An add never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && (s1_cmd_reg == CMD_ADD) && !out_valid_reg |=> !m_axis_tvalid)
    else $error("add request produced a result");

    // A read of a bin that does not exist returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_done && (s1_cmd_reg == CMD_READ) && !s1_range_reg
            |=> m_axis_tvalid && (m_axis_tdata[COUNT_WIDTH-1:0] == '0))
    else $error("read of a missing bin returned a nonzero count");

endmodule

FILE: bench/tb_row_histogram_101_bins.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_row_histogram_101_bins
// Self-checking bench for the row histogram: it streams add and read requests
// into the block, keeps its own copy of the bin store, and compares every
// bin read that comes back against the count predicted for it.
// ============================================================================
module tb_row_histogram_101_bins;

    import rhist_pkg::*;

    localparam int OUT_W      = ((COUNT_WIDTH_DEF + SEL_W + 7) / 8) * 8;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LEN   = 300;
    localparam int RANDOM_REQS = 1650;
    localparam int FILL_ADDS  = 200;

    // One request as the host sees it, before packing onto the stream.
    typedef struct {
        cmd_t                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [SEL_W-1:0]           bin_select;
    } hist_req_t;

    // One bin read as it should come back on the result stream.
    typedef struct {
        logic [COUNT_WIDTH_DEF-1:0] count;
        logic [SEL_W-1:0]           bin_number;
    } bin_read_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    hist_req_t                  pending_reqs[$];
    bin_read_t                  expected_reads[$];
    logic [COUNT_WIDTH_DEF-1:0] bin_model [0:NUM_BINS_DEF-1];

    int   reqs_in_flight = 0;
    int   err_count = 0;
    int   stall_cycles = 0;
    int   hold_left = 0;
    bit   hold_start = 1'b0;
    bit   idle_on = 1'b1;
    bit   req_taken = 1'b0;

    row_histogram_101_bins u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Bin of a score: floor(score * 100) in exact integer arithmetic, with
    // negative scores sent to the bottom bin and anything past the top clamped.
    function automatic int score_bin(input logic signed [SAMPLE_W-1:0] sample);
        int score;
        int idx;
        score = int'(sample);
        if (score < 0)
        begin
            return 0;
        end
        idx = (score * int'(SCALE)) >>> FRAC_BITS;
        if (idx > NUM_BINS_DEF - 1)
        begin
            idx = NUM_BINS_DEF - 1;
        end
        return idx;
    endfunction

    // Applies one accepted request to the local bin store. A read yields the
    // count it should return; reads past the last bin return zero and leave
    // the store alone.
    task automatic histogram_apply(input cmd_t cmd,
                                   input logic signed [SAMPLE_W-1:0] sample,
                                   input logic [SEL_W-1:0] bin_select);
        int        b;
        bin_read_t rd;
        if (cmd == CMD_ADD)
        begin
            b = score_bin(sample);
            // Counters saturate instead of wrapping.
            if (bin_model[b] != '1)
            begin
                bin_model[b] = bin_model[b] + 1'b1;
            end
        end
        else
        begin
            rd.count = '0;
            rd.bin_number = bin_select;
            if (int'(bin_select) < NUM_BINS_DEF)
            begin
                rd.count = bin_model[bin_select];
                bin_model[bin_select] = '0;
            end
            expected_reads.push_back(rd);
        end
    endtask

    task automatic queue_req(input cmd_t cmd, input int sample, input int bin_select);
        hist_req_t r;
        r.cmd = cmd;
        r.sample = sample[SAMPLE_W-1:0];
        r.bin_select = bin_select[SEL_W-1:0];
        pending_reqs.push_back(r);
        reqs_in_flight++;
    endtask

    // Mostly scores in the usual 0 .. 1.0 range, with extra weight on the
    // edges between bins, plus some negative and some past-the-top values.
    function automatic int pick_score();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return -int'($urandom_range(1, 262144));
        end
        if (r < 20)
        begin
            return int'($urandom_range(65536, 262143));
        end
        if (r < 40)
        begin
            k = $urandom_range(1, 100);
            return (k * 65536 + 99) / 100 - 1 + int'($urandom_range(0, 2));
        end
        return int'($urandom_range(0, 65535));
    endfunction

    // Blocks until every queued request is accepted and every read returned.
    task automatic wait_drained();
        wait (reqs_in_flight == 0);
        wait (expected_reads.size() == 0);
        @(posedge clk);
    endtask

    // Driver: offers the next pending request at the falling edge once the
    // previous one was taken, sometimes leaving a gap instead.
    always @(negedge clk)
    begin
        hist_req_t next_req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || req_taken)
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(0, 99) < 33))
            begin
                next_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, next_req.bin_select, next_req.sample};
                s_axis_tuser  <= next_req.cmd;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Request acceptance: each request taken by the block runs through the
    // local bin store right away, so expectations line up in order.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            histogram_apply(cmd_t'(s_axis_tuser), s_axis_tdata[SAMPLE_W-1:0],
                            s_axis_tdata[SAMPLE_W +: SEL_W]);
            req_taken = 1'b1;
            reqs_in_flight--;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when asked for,
    // so the block fills up and stops taking requests.
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 33);
        end
    end

    // Monitor: every returned bin read is checked against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        bin_read_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_reads.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                begin
                    $display("unexpected bin read: count %0d bin %0d",
                             m_axis_tdata[COUNT_WIDTH_DEF-1:0],
                             m_axis_tdata[COUNT_WIDTH_DEF +: SEL_W]);
                end
            end
            else
            begin
                want = expected_reads.pop_front();
                if (m_axis_tdata[COUNT_WIDTH_DEF-1:0] !== want.count
                    || m_axis_tdata[COUNT_WIDTH_DEF +: SEL_W] !== want.bin_number)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("bin read mismatch: expected count %0d bin %0d, got count %0d bin %0d",
                                 want.count, want.bin_number,
                                 m_axis_tdata[COUNT_WIDTH_DEF-1:0],
                                 m_axis_tdata[COUNT_WIDTH_DEF +: SEL_W]);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side means a hang.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles == STALL_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int n_sent;
        int row_len;
        int n_reads;
        int i;
        for (i = 0; i < NUM_BINS_DEF; i++)
        begin
            bin_model[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: bin edges, both ends of the score range, reads past the
        // last bin, and a re-read of a bin that was just cleared.
        queue_req(CMD_ADD, 0, 0);
        queue_req(CMD_ADD, 655, 127);         // just under 0.01
        queue_req(CMD_ADD, 656, 0);           // first score of bin 1
        queue_req(CMD_ADD, 65535, 0);         // just under 1.00
        queue_req(CMD_ADD, 65536, 0);         // exactly 1.00
        queue_req(CMD_ADD, 262143, 0);        // largest score, clamps to top
        queue_req(CMD_ADD, -1, 0);            // negative goes to bin 0
        queue_req(CMD_ADD, -262144, 0);       // most negative score
        queue_req(CMD_ADD, 32768, 0);         // 0.5 lands in bin 50
        queue_req(CMD_READ, 0, 0);
        queue_req(CMD_READ, 0, 1);
        queue_req(CMD_READ, 0, 99);
        queue_req(CMD_READ, -1, 100);
        queue_req(CMD_READ, 0, 50);
        queue_req(CMD_READ, 0, 101);
        queue_req(CMD_READ, 0, 127);
        queue_req(CMD_READ, 0, 0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering reads.
        hold_start = 1'b1;
        for (i = 0; i < 120; i++)
        begin
            if (i % 3 == 0)
            begin
                queue_req(CMD_ADD, pick_score(), $urandom_range(0, 127));
            end
            else
            begin
                queue_req(CMD_READ, pick_score(), $urandom_range(0, 100));
            end
        end
        // The sender then waits for every outstanding read to come back.
        wait_drained();

        // Pile adds into bin 0 back to back with no idling on either side,
        // then read it twice: the full count, then cleared.
        idle_on = 1'b0;
        for (i = 0; i < FILL_ADDS; i++)
        begin
            queue_req(CMD_ADD, -int'($urandom_range(1, 262144)), $urandom_range(0, 127));
        end
        queue_req(CMD_READ, 0, 0);
        queue_req(CMD_READ, 0, 0);
        wait_drained();
        idle_on = 1'b1;

        // Random rows: a run of scores, then a drain of some or all bins,
        // with a few stray reads in the middle of a row.
        n_sent = 0;
        while (n_sent < RANDOM_REQS)
        begin
            row_len = $urandom_range(1, 60);
            for (i = 0; i < row_len; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    queue_req(CMD_READ, pick_score(), $urandom_range(0, 127));
                end
                else
                begin
                    queue_req(CMD_ADD, pick_score(), $urandom_range(0, 127));
                end
            end
            n_sent += row_len;
            if ($urandom_range(0, 7) == 0)
            begin
                for (i = 0; i < NUM_BINS_DEF; i++)
                begin
                    queue_req(CMD_READ, pick_score(), i);
                end
                n_sent += NUM_BINS_DEF;
            end
            else
            begin
                n_reads = $urandom_range(1, 12);
                for (i = 0; i < n_reads; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        queue_req(CMD_READ, pick_score(), $urandom_range(101, 127));
                    end
                    else
                    begin
                        queue_req(CMD_READ, pick_score(), $urandom_range(0, 100));
                    end
                end
                n_sent += n_reads;
            end
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (expected_reads.size() != 0)
        begin
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
